@@ rtl/gsbf_pkg.sv @@
package gsbf_pkg;

	localparam logic [15:0] MAX_BLOCK = 16'hFFFF;
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] ALL_ONES = 32'hFFFFFFFF;
	localparam logic [7:0] BFINAL_SET = 8'h01;
	localparam logic [7:0] BFINAL_CLR = 8'h00;

	localparam int HEAD_LEN = 10;
	localparam int BLK_LEN = 5;
	localparam int TRL_LEN = 8;
	localparam int IDX_W = 4;

	// depth must be a power of two
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		OP_START = 1'b0,
		OP_BYTE = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_HEAD,
		BK_BLK,
		BK_DATA,
		BK_TRL,
		BK_ERR
	} bk_state_t;

	// one input item, classified
	typedef struct packed {
		logic is_err;
		logic has_head;
		logic has_blk;
		logic blk_final;
		logic [15:0] blk_len;
		logic has_data;
		logic [7:0] data;
		logic has_trl;
		logic [31:0] crc;
		logic [31:0] isize;
	} job_t;

	function automatic logic [7:0] gz_head_byte(input logic [IDX_W-1:0] idx);
		logic [7:0] b;
		case (idx)
			4'd0: b = 8'h1f;
			4'd1: b = 8'h8b;
			4'd2: b = 8'h08;
			4'd9: b = 8'hff;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
		end
		return c;
	endfunction

endpackage

@@ rtl/gsbf_ifs.sv @@
interface gsbf_in_if;
	import gsbf_pkg::*;
	logic valid;
	logic ready;
	logic op;
	logic [7:0] data_byte;
	modport source (output valid, output op, output data_byte, input ready);
	modport sink (input valid, input op, input data_byte, output ready);
endinterface

interface gsbf_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic run_last;
	logic stream_end;
	logic error;
	modport source (output valid, output out_byte, output run_last, output stream_end,
		output error, input ready);
	modport sink (input valid, input out_byte, input run_last, input stream_end,
		input error, output ready);
endinterface

interface gsbf_cfg_if;
	logic valid;
	logic ready;
	logic [31:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/gsbf_front.sv @@
module gsbf_front
	import gsbf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	gsbf_in_if.sink in_ch,
	gsbf_cfg_if.sink cfg,
	input logic q_full,
	output logic push,
	output job_t push_job
);

	logic [31:0] total_len_q;
	logic [31:0] crc_q;
	logic [31:0] bytes_seen_q;
	logic [15:0] block_left_q;
	logic open_q;

	logic [32:0] rem;
	logic stray;
	logic need_blk;
	logic blk_final;
	logic [15:0] chunk;
	logic last_byte;
	logic [31:0] crc_nx;
	logic is_start;

	assign cfg.ready = 1'b1;
	assign in_ch.ready = !q_full;
	assign push = in_ch.valid && in_ch.ready;
	assign is_start = (in_ch.op == OP_START);

	always_comb begin
		rem = {1'b0, total_len_q} - {1'b0, bytes_seen_q};
		stray = !open_q || rem[32] || (rem[31:0] == 32'd0);
		need_blk = (block_left_q == 16'd0);
		blk_final = (rem[31:0] <= {16'd0, MAX_BLOCK});
		chunk = blk_final ? rem[15:0] : MAX_BLOCK;
		last_byte = (rem[31:0] == 32'd1);
		crc_nx = crc_byte(crc_q, in_ch.data_byte);
	end

	always_comb begin
		push_job = '0;
		push_job.data = in_ch.data_byte;
		push_job.isize = total_len_q;
		if (is_start) begin
			push_job.has_head = 1'b1;
			if (total_len_q == 32'd0) begin
				// empty stream: final empty block and trailer with zero crc
				push_job.has_blk = 1'b1;
				push_job.blk_final = 1'b1;
				push_job.blk_len = 16'd0;
				push_job.has_trl = 1'b1;
				push_job.crc = ALL_ONES ^ ALL_ONES;
			end
		end else if (stray) begin
			push_job.is_err = 1'b1;
		end else begin
			push_job.has_blk = need_blk;
			push_job.blk_final = blk_final;
			push_job.blk_len = chunk;
			push_job.has_data = 1'b1;
			push_job.has_trl = last_byte;
			push_job.crc = crc_nx ^ ALL_ONES;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_len_q <= 32'd0;
		end else if (cfg.valid && cfg.ready) begin
			total_len_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= ALL_ONES;
			bytes_seen_q <= 32'd0;
			block_left_q <= 16'd0;
			open_q <= 1'b0;
		end else if (push) begin
			if (is_start) begin
				crc_q <= ALL_ONES;
				bytes_seen_q <= 32'd0;
				block_left_q <= 16'd0;
				open_q <= (total_len_q != 32'd0);
			end else if (!stray) begin
				crc_q <= crc_nx;
				bytes_seen_q <= bytes_seen_q + 32'd1;
				block_left_q <= (need_blk ? chunk : block_left_q) - 16'd1;
				if (last_byte) begin
					open_q <= 1'b0;
				end
			end
		end
	end

endmodule

@@ rtl/gsbf_queue.sv @@
module gsbf_queue
	import gsbf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic push,
	input job_t push_job,
	input logic pop,
	output job_t pop_job,
	output logic full,
	output logic empty
);

	job_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + QCNT_W'(1);
				2'b01: cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ rtl/gsbf_back.sv @@
module gsbf_back
	import gsbf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic q_empty,
	input job_t q_job,
	output logic pop,
	gsbf_out_if.source out_ch
);

	bk_state_t state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	job_t job_q, job_d;

	logic out_valid_q;
	logic [7:0] out_byte_q;
	logic run_last_q;
	logic stream_end_q;
	logic error_q;

	logic advance;
	logic emit;
	logic phase_done;
	bk_state_t after_c;
	logic [7:0] byte_c;
	logic err_c;
	logic end_c;
	logic last_c;

	function automatic bk_state_t first_phase(input job_t j);
		bk_state_t s;
		if (j.is_err) begin
			s = BK_ERR;
		end else if (j.has_head) begin
			s = BK_HEAD;
		end else if (j.has_blk) begin
			s = BK_BLK;
		end else begin
			s = BK_DATA;
		end
		return s;
	endfunction

	assign advance = !out_valid_q || out_ch.ready;

	always_comb begin
		byte_c = 8'h00;
		err_c = 1'b0;
		end_c = 1'b0;
		phase_done = 1'b0;
		after_c = BK_IDLE;
		case (state_q)
			BK_HEAD: begin
				byte_c = gz_head_byte(idx_q);
				phase_done = (idx_q == IDX_W'(HEAD_LEN - 1));
				after_c = job_q.has_blk ? BK_BLK : (job_q.has_trl ? BK_TRL : BK_IDLE);
			end
			BK_BLK: begin
				case (idx_q)
					4'd0: byte_c = job_q.blk_final ? BFINAL_SET : BFINAL_CLR;
					4'd1: byte_c = job_q.blk_len[7:0];
					4'd2: byte_c = job_q.blk_len[15:8];
					4'd3: byte_c = ~job_q.blk_len[7:0];
					default: byte_c = ~job_q.blk_len[15:8];
				endcase
				phase_done = (idx_q == IDX_W'(BLK_LEN - 1));
				after_c = job_q.has_data ? BK_DATA : (job_q.has_trl ? BK_TRL : BK_IDLE);
			end
			BK_DATA: begin
				byte_c = job_q.data;
				phase_done = 1'b1;
				after_c = job_q.has_trl ? BK_TRL : BK_IDLE;
			end
			BK_TRL: begin
				case (idx_q)
					4'd0: byte_c = job_q.crc[7:0];
					4'd1: byte_c = job_q.crc[15:8];
					4'd2: byte_c = job_q.crc[23:16];
					4'd3: byte_c = job_q.crc[31:24];
					4'd4: byte_c = job_q.isize[7:0];
					4'd5: byte_c = job_q.isize[15:8];
					4'd6: byte_c = job_q.isize[23:16];
					default: byte_c = job_q.isize[31:24];
				endcase
				phase_done = (idx_q == IDX_W'(TRL_LEN - 1));
				end_c = phase_done;
				after_c = BK_IDLE;
			end
			BK_ERR: begin
				err_c = 1'b1;
				phase_done = 1'b1;
				after_c = BK_IDLE;
			end
			default: begin
				phase_done = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		job_d = job_q;
		pop = 1'b0;
		emit = 1'b0;
		last_c = 1'b0;
		if (state_q == BK_IDLE) begin
			if (!q_empty) begin
				pop = 1'b1;
				job_d = q_job;
				state_d = first_phase(q_job);
				idx_d = '0;
			end
		end else if (advance) begin
			emit = 1'b1;
			if (phase_done) begin
				idx_d = '0;
				if (after_c == BK_IDLE) begin
					last_c = 1'b1;
					// chain straight into the next job
					if (!q_empty) begin
						pop = 1'b1;
						job_d = q_job;
						state_d = first_phase(q_job);
					end else begin
						state_d = BK_IDLE;
					end
				end else begin
					state_d = after_c;
				end
			end else begin
				idx_d = idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		job_q <= job_d;
		if (emit) begin
			out_byte_q <= byte_c;
			run_last_q <= last_c;
			stream_end_q <= end_c;
			error_q <= err_c;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.out_byte = out_byte_q;
	assign out_ch.run_last = run_last_q;
	assign out_ch.stream_end = stream_end_q;
	assign out_ch.error = error_q;

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && stream_end_q |-> run_last_q && !error_q)
		else $error("trailer end beat not marked last");

	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && error_q |-> out_byte_q == 8'h00 && run_last_q)
		else $error("error beat malformed");

	a_data_phase: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_DATA |-> job_q.has_data && !job_q.is_err)
		else $error("data phase without payload byte");

	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q != BK_IDLE && idx_q == '0)
		else $error("popped job not started");

endmodule

@@ rtl/gzip_stored_block_framer.sv @@
// gzip framer for uncompressed (stored) deflate streams.
// cfg: write total_length (payload bytes, also ISIZE) before a start item,
// while the block is idle. cfg.ready is always high.
// in_ch: op 0 starts a stream and emits the 10-byte gzip header (and for
// length zero also the empty final block and the trailer); op 1 carries one
// payload byte. a byte that opens a block is preceded by a 5-byte block
// header, the last byte is followed by the 8-byte crc/isize trailer.
// stray bytes give a single error beat with out_byte 0.
// out_ch: one output byte per beat, run_last on the last beat of each item,
// stream_end on the final trailer byte.
// throughput: one output beat per cycle while out_ch is ready; payload items go in
// one per cycle while no header or trailer is due, and header and trailer bytes
// hold the byte sequencer, which sits behind a 2-entry job queue.
// reset clears the length register, crc and stream state; no stream is open.
// a stalled receiver holds the output register; the queue fills and in_ch
// ready drops once the queue holds two items.
module gzip_stored_block_framer
	import gsbf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	gsbf_in_if.sink in_ch,
	gsbf_cfg_if.sink cfg,
	gsbf_out_if.source out_ch
);

	logic q_full;
	logic q_empty;
	logic push;
	logic pop;
	job_t push_job;
	job_t pop_job;

	gsbf_front u_front (
		.clk (clk),
		.arst_n (arst_n),
		.in_ch (in_ch),
		.cfg (cfg),
		.q_full (q_full),
		.push (push),
		.push_job (push_job)
	);

	gsbf_queue u_queue (
		.clk (clk),
		.arst_n (arst_n),
		.push (push),
		.push_job (push_job),
		.pop (pop),
		.pop_job (pop_job),
		.full (q_full),
		.empty (q_empty)
	);

	gsbf_back u_back (
		.clk (clk),
		.arst_n (arst_n),
		.q_empty (q_empty),
		.q_job (pop_job),
		.pop (pop),
		.out_ch (out_ch)
	);

endmodule
